// File: hw/rtl/sov_pkg.sv
package sov_pkg;

  localparam int COUNT_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int VAL_BITS     = 48;
  localparam int LABEL_BITS   = 16;
  localparam int KIND_BITS    = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int N_CAT        = 8;
  localparam int CAT_IDX_BITS = $clog2(N_CAT);

  // numerator is a sum of two counters, scale is at most 100 << FRAC_BITS
  localparam int NUMER_W = COUNT_BITS + 1;
  localparam int SCALE_W = 7 + FRAC_BITS;
  localparam int NUM_W   = NUMER_W + SCALE_W;
  localparam int DEN_W   = COUNT_BITS + 1;
  localparam int EXT_W   = (NUM_W > VAL_BITS) ? NUM_W : VAL_BITS;
  localparam int STEP_W  = $clog2(NUM_W);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [KIND_BITS-1:0]  kind_t;
  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [CAT_IDX_BITS-1:0] cat_idx_t;

  localparam kind_t KIND_OVERLAP   = 5'd0;
  localparam kind_t KIND_TEST      = 5'd1;
  localparam kind_t KIND_TRUTH     = 5'd2;
  localparam kind_t KIND_UNION     = 5'd3;
  localparam kind_t KIND_FP        = 5'd4;
  localparam kind_t KIND_FN        = 5'd5;
  localparam kind_t KIND_TN        = 5'd6;
  localparam kind_t KIND_NEG       = 5'd7;
  localparam kind_t KIND_TOTAL     = 5'd8;
  localparam kind_t KIND_DICE      = 5'd9;
  localparam kind_t KIND_OV_TRUTH  = 5'd10;
  localparam kind_t KIND_OV_TEST   = 5'd11;
  localparam kind_t KIND_JACCARD   = 5'd12;
  localparam kind_t KIND_SENS      = 5'd13;
  localparam kind_t KIND_SPEC      = 5'd14;
  localparam kind_t KIND_PPV       = 5'd15;
  localparam kind_t KIND_OVERSEG   = 5'd16;

  localparam cat_idx_t C_OV    = 3'd0;
  localparam cat_idx_t C_TEST  = 3'd1;
  localparam cat_idx_t C_TRUTH = 3'd2;
  localparam cat_idx_t C_UNION = 3'd3;
  localparam cat_idx_t C_FP    = 3'd4;
  localparam cat_idx_t C_FN    = 3'd5;
  localparam cat_idx_t C_TN    = 3'd6;
  localparam cat_idx_t C_NEG   = 3'd7;

  localparam cfg_idx_t CFG_TEST_LABEL  = 2'd0;
  localparam cfg_idx_t CFG_TRUTH_LABEL = 2'd1;
  localparam cfg_idx_t CFG_MASK_ENABLE = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_PCT  = SCALE_W'(100) << FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_DICE = SCALE_W'(2) << FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1) << FRAC_BITS;

  localparam logic [VAL_BITS-1:0] VAL_MAX = {VAL_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_COUNTS_OUT,
    ST_MUL,
    ST_DIV,
    ST_METRIC_OUT
  } state_t;

  typedef struct packed {
    logic  count;
    logic  clear;
    logic  out_load;
    logic  metric;
    logic  mul_load;
    logic  div_step;
    kind_t kind;
  } ctl_t;

endpackage

// File: hw/rtl/sov_if.sv
interface sov_voxel_if;
  import sov_pkg::*;
  logic   valid;
  logic   ready;
  label_t test_voxel;
  label_t truth_voxel;
  label_t mask_voxel;
  logic   end_of_volume;
  modport source (output valid, test_voxel, truth_voxel, mask_voxel, end_of_volume,
                  input ready);
  modport sink (input valid, test_voxel, truth_voxel, mask_voxel, end_of_volume,
                output ready);
endinterface

interface sov_result_if;
  import sov_pkg::*;
  logic                valid;
  logic                ready;
  kind_t               result_kind;
  logic [VAL_BITS-1:0] result_value;
  logic                undefined;
  logic                sens_spec_meaningful;
  logic                last_of_run;
  modport source (output valid, result_kind, result_value, undefined,
                  sens_spec_meaningful, last_of_run, input ready);
  modport sink (input valid, result_kind, result_value, undefined,
                sens_spec_meaningful, last_of_run, output ready);
endinterface

interface sov_cfg_if;
  import sov_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  label_t   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/segmentation_overlap_metrics.sv
// channel   dir  payload
// voxel     in   test_voxel, truth_voxel, mask_voxel, end_of_volume
// result    out  result_kind, result_value, undefined, sens_spec_meaningful, last_of_run
// cfg       in   index, data (test_label, truth_label, mask_enable)
//
// one voxel request per cycle while counting
// after the last voxel: 9 counts at one per cycle while the receiver accepts them, then each of the 8 metrics
// is computed in the shared bit-serial divider
// no voxel is taken from the last voxel until the final metric is loaded
// a stalled result holds in the output register and stalls the sequence
// rst is synchronous; it clears counters, labels to 1 and mask_enable to 0
module segmentation_overlap_metrics (
  input  logic                clk,
  input  logic                rst,
  sov_voxel_if.sink           voxel,
  sov_result_if.source        result,
  sov_cfg_if.sink             cfg
);
  import sov_pkg::*;

  ctl_t ctl;
  logic in_ready;
  logic out_free;

  assign voxel.ready = in_ready;
  assign cfg.ready   = 1'b1;

  sov_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (voxel.valid),
    .in_last  (voxel.end_of_volume),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  sov_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .ctl                  (ctl),
    .test_voxel           (voxel.test_voxel),
    .truth_voxel          (voxel.truth_voxel),
    .mask_voxel           (voxel.mask_voxel),
    .cfg_we               (cfg.valid),
    .cfg_index            (cfg.index),
    .cfg_data             (cfg.data),
    .out_ready            (result.ready),
    .out_free             (out_free),
    .out_valid            (result.valid),
    .result_kind          (result.result_kind),
    .result_value         (result.result_value),
    .undefined            (result.undefined),
    .sens_spec_meaningful (result.sens_spec_meaningful),
    .last_of_run          (result.last_of_run)
  );

  a_last_voxel_stops_input: assert property (@(posedge clk) disable iff (rst)
    (voxel.valid && voxel.ready && voxel.end_of_volume) |=> !voxel.ready)
    else $error("voxel taken right after last voxel of volume");

  a_counts_defined: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.result_kind <= KIND_TOTAL)) |-> !result.undefined)
    else $error("count flagged undefined");

  a_undefined_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.undefined) |-> (result.result_value == '0))
    else $error("undefined metric with nonzero value");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_of_run) |-> (result.result_kind == KIND_OVERSEG))
    else $error("end of run on wrong result kind");

endmodule

// File: hw/rtl/sov_ctrl.sv
module sov_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  input  logic          out_free,
  output logic          in_ready,
  output sov_pkg::ctl_t ctl
);
  import sov_pkg::*;

  state_t             state, state_next;
  kind_t              kind, kind_next;
  logic [STEP_W-1:0]  step, step_next;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COUNT;
      kind  <= KIND_OVERLAP;
      step  <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    step_next  = step;
    unique case (state)
      ST_COUNT: begin
        if (in_valid && in_last) begin
          state_next = ST_COUNTS_OUT;
          kind_next  = KIND_OVERLAP;
        end
      end
      ST_COUNTS_OUT: begin
        if (out_free) begin
          kind_next = kind + 5'd1;
          if (kind == KIND_TOTAL) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = ST_METRIC_OUT;
        end
      end
      ST_METRIC_OUT: begin
        if (out_free) begin
          if (kind == KIND_OVERSEG) begin
            state_next = ST_COUNT;
            kind_next  = KIND_OVERLAP;
          end else begin
            kind_next  = kind + 5'd1;
            state_next = ST_MUL;
          end
        end
      end
      default: state_next = ST_COUNT;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.kind     = kind;
    unique case (state)
      ST_COUNT: begin
        in_ready  = 1'b1;
        ctl.count = in_valid;
      end
      ST_COUNTS_OUT: begin
        ctl.out_load = out_free;
      end
      ST_MUL: begin
        ctl.mul_load = 1'b1;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
      end
      ST_METRIC_OUT: begin
        ctl.out_load = out_free;
        ctl.metric   = 1'b1;
        ctl.clear    = out_free && (kind == KIND_OVERSEG);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/sov_dp.sv
module sov_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  sov_pkg::ctl_t                ctl,
  input  sov_pkg::label_t              test_voxel,
  input  sov_pkg::label_t              truth_voxel,
  input  sov_pkg::label_t              mask_voxel,
  input  logic                         cfg_we,
  input  sov_pkg::cfg_idx_t            cfg_index,
  input  sov_pkg::label_t              cfg_data,
  input  logic                         out_ready,
  output logic                         out_free,
  output logic                         out_valid,
  output sov_pkg::kind_t               result_kind,
  output logic [sov_pkg::VAL_BITS-1:0] result_value,
  output logic                         undefined,
  output logic                         sens_spec_meaningful,
  output logic                         last_of_run
);
  import sov_pkg::*;

  label_t test_label;
  label_t truth_label;
  logic   mask_enable;

  count_t cat [N_CAT];
  count_t total;

  logic              counted;
  logic              tf, gf, tz, gz;
  logic [N_CAT-1:0]  hit;
  logic              meaningful;

  logic [NUMER_W-1:0] numer;
  logic [SCALE_W-1:0] scale;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   prod;

  logic [DEN_W-1:0]   den_r;
  logic               den_zero;
  logic [NUM_W-1:0]   dq;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [DEN_W-1:0]   rem_next;

  logic [EXT_W-1:0]    q_ext;
  logic [VAL_BITS-1:0] metric_value;
  logic [VAL_BITS-1:0] count_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      test_label  <= LABEL_BITS'(1);
      truth_label <= LABEL_BITS'(1);
      mask_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEST_LABEL:  test_label  <= cfg_data;
        CFG_TRUTH_LABEL: truth_label <= cfg_data;
        CFG_MASK_ENABLE: mask_enable <= cfg_data[0];
        default:         mask_enable <= mask_enable;
      endcase
    end
  end

  // voxel classification
  always_comb begin
    counted    = !mask_enable || (!mask_voxel[LABEL_BITS-1] && (mask_voxel != '0));
    tf         = (test_voxel == test_label);
    gf         = (truth_voxel == truth_label);
    tz         = (test_voxel == '0);
    gz         = (truth_voxel == '0);
    hit        = '0;
    hit[C_OV]    = tf && gf;
    hit[C_TEST]  = tf;
    hit[C_TRUTH] = gf;
    hit[C_UNION] = tf || gf;
    hit[C_FP]    = tf && gz;
    hit[C_FN]    = tz && gf;
    hit[C_TN]    = tz && gz;
    hit[C_NEG]   = gz;
  end

  // saturating counters
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < N_CAT; i++) begin
        cat[i] <= '0;
      end
      total <= '0;
    end else if (ctl.count) begin
      for (int i = 0; i < N_CAT; i++) begin
        if (counted && hit[i] && (cat[i] != '1)) begin
          cat[i] <= cat[i] + 1'b1;
        end
      end
      if (total != '1) begin
        total <= total + 1'b1;
      end
    end
  end

  assign meaningful = (cat[C_TRUTH] != '0) && (cat[C_NEG] != '0);

  // metric operand selection
  always_comb begin
    numer = NUMER_W'(cat[C_OV]);
    scale = SCALE_PCT;
    den   = '0;
    unique case (ctl.kind)
      KIND_DICE: begin
        scale = SCALE_DICE;
        den   = DEN_W'(cat[C_TEST]) + DEN_W'(cat[C_TRUTH]);
      end
      KIND_OV_TRUTH: den = DEN_W'(cat[C_TRUTH]);
      KIND_OV_TEST:  den = DEN_W'(cat[C_TEST]);
      KIND_JACCARD: begin
        scale = SCALE_ONE;
        den   = DEN_W'(cat[C_UNION]);
      end
      KIND_SENS: den = DEN_W'(cat[C_OV]) + DEN_W'(cat[C_FN]);
      KIND_SPEC: begin
        numer = NUMER_W'(cat[C_TN]);
        den   = DEN_W'(cat[C_TN]) + DEN_W'(cat[C_FP]);
      end
      KIND_PPV: den = DEN_W'(cat[C_OV]) + DEN_W'(cat[C_FP]);
      KIND_OVERSEG: begin
        numer = NUMER_W'(cat[C_OV]) + NUMER_W'(cat[C_FP]);
        den   = DEN_W'(cat[C_OV]) + DEN_W'(cat[C_FN]);
      end
      default: den = '0;
    endcase
  end

  assign prod = NUM_W'(numer) * NUM_W'(scale);

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem, dq[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      dq       <= prod;
      den_r    <= den;
      den_zero <= (den == '0);
      rem      <= '0;
    end else if (ctl.div_step) begin
      dq  <= {dq[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  always_comb begin
    q_ext = EXT_W'(dq);
    if (den_zero) begin
      metric_value = '0;
    end else if (q_ext > EXT_W'(VAL_MAX)) begin
      metric_value = VAL_MAX;
    end else begin
      metric_value = q_ext[VAL_BITS-1:0];
    end
    if (ctl.kind == KIND_TOTAL) begin
      count_value = VAL_BITS'(total);
    end else begin
      count_value = VAL_BITS'(cat[ctl.kind[CAT_IDX_BITS-1:0]]);
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result_kind          <= ctl.kind;
      result_value         <= ctl.metric ? metric_value : count_value;
      undefined            <= ctl.metric && den_zero;
      sens_spec_meaningful <= meaningful;
      last_of_run          <= (ctl.kind == KIND_OVERSEG);
    end
  end

endmodule

// File: tb/overlap_metrics_checker.sv
`timescale 1ns / 1ps

module overlap_metrics_checker (
  input  logic         clk,
  input  logic         rst,
  sov_voxel_if         voxel,
  sov_result_if        result,
  sov_cfg_if           cfg,
  output int           fail_count,
  output int           outstanding
);
  import sov_pkg::*;

  typedef struct packed {
    kind_t               kind;
    logic [VAL_BITS-1:0] value;
    logic                undef;
    logic                meaningful;
    logic                last_flag;
  } metric_result_t;

  metric_result_t expected_results[$];

  count_t tally[N_CAT];
  count_t total_voxels;
  label_t test_label;
  label_t truth_label;
  logic   mask_on;
  logic   run_meaningful;

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void push_result(kind_t k, logic [VAL_BITS-1:0] v, logic undef);
    metric_result_t r;
    r.kind       = k;
    r.value      = v;
    r.undef      = undef;
    r.meaningful = run_meaningful;
    r.last_flag  = (k == KIND_OVERSEG);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void push_metric(kind_t k, logic [63:0] num, logic [63:0] scale,
                                      logic [63:0] den);
    logic [63:0] q;
    if (den == 64'd0) begin
      push_result(k, '0, 1'b1);
    end else begin
      q = (num * scale) / den;
      if (q > 64'(VAL_MAX)) begin
        q = 64'(VAL_MAX);
      end
      push_result(k, q[VAL_BITS-1:0], 1'b0);
    end
  endfunction

  function automatic void close_volume();
    run_meaningful = (tally[C_TRUTH] != '0) && (tally[C_NEG] != '0);
    push_result(KIND_OVERLAP, VAL_BITS'(tally[C_OV]), 1'b0);
    push_result(KIND_TEST, VAL_BITS'(tally[C_TEST]), 1'b0);
    push_result(KIND_TRUTH, VAL_BITS'(tally[C_TRUTH]), 1'b0);
    push_result(KIND_UNION, VAL_BITS'(tally[C_UNION]), 1'b0);
    push_result(KIND_FP, VAL_BITS'(tally[C_FP]), 1'b0);
    push_result(KIND_FN, VAL_BITS'(tally[C_FN]), 1'b0);
    push_result(KIND_TN, VAL_BITS'(tally[C_TN]), 1'b0);
    push_result(KIND_NEG, VAL_BITS'(tally[C_NEG]), 1'b0);
    push_result(KIND_TOTAL, VAL_BITS'(total_voxels), 1'b0);
    push_metric(KIND_DICE, 64'(tally[C_OV]), 64'(SCALE_DICE),
                64'(tally[C_TEST]) + 64'(tally[C_TRUTH]));
    push_metric(KIND_OV_TRUTH, 64'(tally[C_OV]), 64'(SCALE_PCT), 64'(tally[C_TRUTH]));
    push_metric(KIND_OV_TEST, 64'(tally[C_OV]), 64'(SCALE_PCT), 64'(tally[C_TEST]));
    push_metric(KIND_JACCARD, 64'(tally[C_OV]), 64'(SCALE_ONE), 64'(tally[C_UNION]));
    push_metric(KIND_SENS, 64'(tally[C_OV]), 64'(SCALE_PCT),
                64'(tally[C_OV]) + 64'(tally[C_FN]));
    push_metric(KIND_SPEC, 64'(tally[C_TN]), 64'(SCALE_PCT),
                64'(tally[C_TN]) + 64'(tally[C_FP]));
    push_metric(KIND_PPV, 64'(tally[C_OV]), 64'(SCALE_PCT),
                64'(tally[C_OV]) + 64'(tally[C_FP]));
    push_metric(KIND_OVERSEG, 64'(tally[C_OV]) + 64'(tally[C_FP]), 64'(SCALE_PCT),
                64'(tally[C_OV]) + 64'(tally[C_FN]));
    for (int i = 0; i < N_CAT; i++) begin
      tally[i] = '0;
    end
    total_voxels = '0;
  endfunction

  function automatic void count_voxel(label_t t, label_t g, label_t m, logic eov);
    logic tf, gf, tz, gz;
    tf = (t == test_label);
    gf = (g == truth_label);
    tz = (t == '0);
    gz = (g == '0);
    // mask only lets strictly positive values through
    if (!mask_on || (m != '0 && !m[LABEL_BITS-1])) begin
      if (tf && gf) tally[C_OV] = sat_inc(tally[C_OV]);
      if (tf) tally[C_TEST] = sat_inc(tally[C_TEST]);
      if (gf) tally[C_TRUTH] = sat_inc(tally[C_TRUTH]);
      if (tf || gf) tally[C_UNION] = sat_inc(tally[C_UNION]);
      if (tf && gz) tally[C_FP] = sat_inc(tally[C_FP]);
      if (tz && gf) tally[C_FN] = sat_inc(tally[C_FN]);
      if (tz && gz) tally[C_TN] = sat_inc(tally[C_TN]);
      if (gz) tally[C_NEG] = sat_inc(tally[C_NEG]);
    end
    total_voxels = sat_inc(total_voxels);
    if (eov) begin
      close_volume();
    end
  endfunction

  always @(posedge clk) begin
    metric_result_t got, want;
    if (rst) begin
      for (int i = 0; i < N_CAT; i++) begin
        tally[i] = '0;
      end
      total_voxels = '0;
      test_label = label_t'(1);
      truth_label = label_t'(1);
      mask_on = 1'b0;
      run_meaningful = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.kind       = result.result_kind;
        got.value      = result.result_value;
        got.undef      = result.undefined;
        got.meaningful = result.sens_spec_meaningful;
        got.last_flag  = result.last_of_run;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result kind %0d value %0d", $time, got.kind, got.value);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.undef !== want.undef || got.meaningful !== want.meaningful ||
              got.last_flag !== want.last_flag) begin
            fail_count++;
            $display("%0t: mismatch, expected kind %0d value %0d undef %0b mean %0b last %0b",
                     $time, want.kind, want.value, want.undef, want.meaningful,
                     want.last_flag);
            $display("%0t:             actual kind %0d value %0d undef %0b mean %0b last %0b",
                     $time, got.kind, got.value, got.undef, got.meaningful, got.last_flag);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TEST_LABEL:  test_label = cfg.data;
          CFG_TRUTH_LABEL: truth_label = cfg.data;
          CFG_MASK_ENABLE: mask_on = cfg.data[0];
          default: ;
        endcase
      end
      if (voxel.valid && voxel.ready) begin
        count_voxel(voxel.test_voxel, voxel.truth_voxel, voxel.mask_voxel,
                    voxel.end_of_volume);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/segmentation_overlap_metrics_test.sv
`timescale 1ns / 1ps

module segmentation_overlap_metrics_test;
  import sov_pkg::*;

  localparam int       CYCLE_LIMIT   = 1000000;
  localparam int       RANDOM_ITEMS  = 250;
  localparam int       SETTLE_CYCLES = 12;
  localparam int       TAIL_CYCLES   = 100;
  localparam int       HOLD_CYCLES   = 400;
  localparam cfg_idx_t CFG_UNUSED    = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;

  label_t test_lbl = label_t'(1);
  label_t truth_lbl = label_t'(1);

  sov_voxel_if  voxel_ch ();
  sov_result_if result_ch ();
  sov_cfg_if    cfg_ch ();

  segmentation_overlap_metrics u_top (
    .clk    (clk),
    .rst    (rst),
    .voxel  (voxel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  overlap_metrics_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .voxel       (voxel_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic label_t pick_value(label_t fg, label_t other);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return fg;
      4, 5:       return '0;
      6:          return other;
      7:          return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
      default:    return label_t'($urandom);
    endcase
  endfunction

  function automatic label_t pick_mask();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return label_t'($urandom_range(1, 32767));
      5:             return '0;
      6, 7:          return {1'b1, 15'($urandom)};
      default:       return label_t'($urandom);
    endcase
  endfunction

  // bursts of requests with random gaps between them
  task automatic send_voxel(label_t t, label_t g, label_t m, logic eov);
    if (burst_left == 0) begin
      voxel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
    voxel_ch.test_voxel    <= t;
    voxel_ch.truth_voxel   <= g;
    voxel_ch.mask_voxel    <= m;
    voxel_ch.end_of_volume <= eov;
    voxel_ch.valid         <= 1'b1;
    do @(posedge clk); while (!voxel_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic write_reg(cfg_idx_t idx, label_t d);
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic configure(label_t tl, label_t gl, logic me);
    voxel_ch.valid <= 1'b0;
    burst_left = 0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_TEST_LABEL, tl);
    write_reg(CFG_TRUTH_LABEL, gl);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_UNUSED, label_t'($urandom));
    end
    write_reg(CFG_MASK_ENABLE, {15'($urandom), me});
    cfg_ch.valid <= 1'b0;
    test_lbl = tl;
    truth_lbl = gl;
  endtask

  // receiver stall patterns, plus one long hold-off on the first random volume's results
  initial begin
    int mode, span, tick;
    result_ch.ready = 1'b0;
    tick = 0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_armed && !hold_done && result_ch.valid) begin
          result_ch.ready <= 1'b0;
          hold_done = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
            default: result_ch.ready <= (tick % 3 != 0);
          endcase
        end
      end
    end
  end

  initial begin
    int n_items, len, volumes, phase;
    rst = 1'b1;
    voxel_ch.valid = 1'b0;
    voxel_ch.test_voxel = '0;
    voxel_ch.truth_voxel = '0;
    voxel_ch.mask_voxel = '0;
    voxel_ch.end_of_volume = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TEST_LABEL;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset labels, every category, mask ignored while disabled
    send_voxel(16'd1, 16'd1, 16'h8000, 1'b0);
    send_voxel(16'd1, 16'd0, 16'd0, 1'b0);
    send_voxel(16'd0, 16'd1, 16'hffff, 1'b0);
    send_voxel(16'd0, 16'd0, 16'd5, 1'b0);
    send_voxel(16'd2, 16'd5, 16'd0, 1'b0);
    send_voxel(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_voxel(16'h8000, 16'h7fff, 16'h8000, 1'b1);
    // single-voxel volumes with zero denominators
    send_voxel(16'd1, 16'd1, 16'd0, 1'b1);
    send_voxel(16'd0, 16'd0, 16'd0, 1'b1);

    // zero labels overlap several categories
    configure(16'd0, 16'd0, 1'b0);
    send_voxel(16'd0, 16'd0, 16'd0, 1'b0);
    send_voxel(16'd0, 16'd5, 16'd0, 1'b0);
    send_voxel(16'd5, 16'd0, 16'd0, 1'b0);
    send_voxel(16'd5, 16'd5, 16'd0, 1'b1);

    // mask enabled, out of range register write
    voxel_ch.valid <= 1'b0;
    burst_left = 0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_UNUSED, 16'hffff);
    cfg_ch.valid <= 1'b0;
    configure(16'd1, 16'd2, 1'b1);
    send_voxel(16'd1, 16'd2, 16'd1, 1'b0);
    send_voxel(16'd1, 16'd2, 16'd0, 1'b0);
    send_voxel(16'd1, 16'd2, 16'hffff, 1'b0);
    send_voxel(16'd0, 16'd2, 16'h7fff, 1'b0);
    send_voxel(16'd1, 16'd0, 16'h8000, 1'b0);
    send_voxel(16'd0, 16'd0, 16'hffff, 1'b1);

    // label extremes
    configure(16'h8000, 16'h7fff, 1'b0);
    send_voxel(16'h8000, 16'h7fff, 16'd0, 1'b0);
    send_voxel(16'h7fff, 16'h8000, 16'd0, 1'b0);
    send_voxel(16'h8000, 16'd0, 16'd0, 1'b0);
    send_voxel(16'd0, 16'h7fff, 16'd0, 1'b1);

    n_items = 0;
    volumes = 0;
    phase = 0;
    while (n_items < RANDOM_ITEMS) begin
      if (volumes % 3 == 0) begin
        case (phase % 6)
          0:       configure(16'd1, 16'd1, 1'b0);
          1:       configure(16'd0, 16'd0, 1'($urandom_range(0, 1)));
          2:       configure(16'h8000, 16'h7fff, 1'b1);
          3:       configure(16'h7fff, 16'h8000, 1'b0);
          default: configure(label_t'($urandom), label_t'($urandom),
                             1'($urandom_range(0, 1)));
        endcase
        phase++;
      end
      // long hold-off on the first random volume, the next one keeps offering
      if (volumes == 0) begin
        hold_armed = 1'b1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40) : $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        send_voxel(pick_value(test_lbl, truth_lbl), pick_value(truth_lbl, test_lbl),
                   pick_mask(), (i == len - 1));
      end
      n_items += len;
      volumes++;
    end

    voxel_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
